>>> design/motor_drive_with_stall_watchdog_core_defines.svh
`ifndef MOTOR_DRIVE_WITH_STALL_WATCHDOG_CORE_DEFINES_SVH
`define MOTOR_DRIVE_WITH_STALL_WATCHDOG_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MDSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdsw check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MDSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdsw check failed");

`endif

>>> design/mdsw_pkg.sv
`default_nettype none

package mdsw_pkg;

  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_DRIVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BRAKE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COAST = 2'd2;

  localparam logic [1:0] CFG_DRIVE_THR = 2'd0;
  localparam logic [1:0] CFG_SPEED_THR = 2'd1;
  localparam logic [1:0] CFG_FAIL_TIME = 2'd2;

  localparam logic signed [15:0] Q_ONE     = 16'sd16384;
  localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;
  localparam int                 Q_FRAC    = 14;
  localparam logic [16:0]        DUTY_MAX  = 17'd1023;

  localparam logic [31:0] TIME_RESET     = 32'hFFFF_EC78;
  localparam logic [14:0] DRIVE_THR_RST  = 15'd8192;
  localparam logic [14:0] SPEED_THR_RST  = 15'd100;
  localparam logic [31:0] FAIL_TIME_RST  = 32'd1000;

  typedef struct packed {
    logic        upd;
    logic        blocked;
    logic [31:0] now;
  } wd_ctl_t;

endpackage

`default_nettype wire

>>> design/motor_drive_with_stall_watchdog_core.sv
// Stages: input register, result register. Throughput: one transaction per cycle unless stalled;
// both register stages advance together on stall release. Pins, duties and, for drive commands,
// the selected wheel's watchdog timestamps update when an item moves into the result register.
// Reset (rst_n low, synchronous): both stages empty, timestamps at -5000 ms, pins and duties zero,
// config registers at their defaults. cfg_ready is always high.
`default_nettype none

module motor_drive_with_stall_watchdog_core #(
  parameter int DUTY_FULL = 1000
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // drive_value[15:0], measured_speed[31:16], now_ms[63:32]
  input  wire logic [2:0]  in_tuser,   // command[1:0], wheel[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // direction_pins[3:0], right_duty[13:4], left_duty[23:14], clamped_drive[39:24],
  // stall_fail[40], zero[47:41]
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [9:0] DUTY_SAT = (DUTY_FULL > 1023) ? 10'd1023 : 10'(DUTY_FULL);

  logic [14:0] drive_thr_r;
  logic [14:0] speed_thr_r;
  logic [31:0] fail_time_r;

  logic        in_v_r;
  logic [63:0] in_data_r;
  logic [2:0]  in_user_r;

  logic        out_v_r;
  logic [47:0] out_data_r;

  logic [3:0]  pins_r, pins_nxt;
  logic [9:0]  rduty_r, rduty_nxt;
  logic [9:0]  lduty_r, lduty_nxt;

  logic        out_adv;
  logic        fire;

  logic [1:0]         cmd;
  logic               wheel;
  logic signed [15:0] spd;
  logic signed [15:0] spd_neg;
  logic [15:0]        smag;
  logic [31:0]        now;

  logic signed [15:0] clamped;
  logic [14:0]        mag;
  logic [9:0]         duty;
  logic               fwd;
  logic               blocked;
  logic               r_stall, l_stall;

  logic signed [15:0] clamped_o;
  logic               stall_o;

  mdsw_pkg::wd_ctl_t r_ctl, l_ctl;

  assign cfg_ready  = 1'b1;
  assign out_adv    = !out_v_r || out_tready;
  assign in_tready  = !in_v_r || out_adv;
  assign fire       = in_v_r && out_adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  assign cmd   = in_user_r[1:0];
  assign wheel = in_user_r[2];
  assign spd   = in_data_r[31:16];
  assign now   = in_data_r[63:32];

  mdsw_drive_calc #(
    .DUTY_FULL(DUTY_FULL)
  ) u_calc (
    .drive_value(in_data_r[15:0]),
    .clamped    (clamped),
    .mag        (mag),
    .duty       (duty),
    .fwd        (fwd)
  );

  always_comb begin
    spd_neg = -spd;
    smag    = spd[15] ? spd_neg : spd;
    blocked = (mag > drive_thr_r) && (smag < {1'b0, speed_thr_r});

    r_ctl.upd     = fire && (cmd == mdsw_pkg::CMD_DRIVE) && !wheel;
    r_ctl.blocked = blocked;
    r_ctl.now     = now;
    l_ctl.upd     = fire && (cmd == mdsw_pkg::CMD_DRIVE) && wheel;
    l_ctl.blocked = blocked;
    l_ctl.now     = now;
  end

  mdsw_wheel_watchdog u_wd_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (r_ctl),
    .fail_time(fail_time_r),
    .stall    (r_stall)
  );

  mdsw_wheel_watchdog u_wd_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (l_ctl),
    .fail_time(fail_time_r),
    .stall    (l_stall)
  );

  always_comb begin
    pins_nxt  = pins_r;
    rduty_nxt = rduty_r;
    lduty_nxt = lduty_r;
    clamped_o = 16'sd0;
    stall_o   = 1'b0;
    unique case (cmd)
      mdsw_pkg::CMD_DRIVE: begin
        clamped_o = clamped;
        if (!wheel) begin
          pins_nxt  = {pins_r[3:2], fwd ? 2'b10 : 2'b01};
          rduty_nxt = duty;
          stall_o   = r_stall;
        end else begin
          pins_nxt  = {fwd ? 2'b01 : 2'b10, pins_r[1:0]};
          lduty_nxt = duty;
          stall_o   = l_stall;
        end
      end
      mdsw_pkg::CMD_BRAKE: begin
        pins_nxt  = 4'hF;
        rduty_nxt = DUTY_SAT;
        lduty_nxt = DUTY_SAT;
      end
      mdsw_pkg::CMD_COAST: begin
        pins_nxt  = 4'h0;
        rduty_nxt = DUTY_SAT;
        lduty_nxt = DUTY_SAT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_thr_r <= mdsw_pkg::DRIVE_THR_RST;
      speed_thr_r <= mdsw_pkg::SPEED_THR_RST;
      fail_time_r <= mdsw_pkg::FAIL_TIME_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mdsw_pkg::CFG_DRIVE_THR: drive_thr_r <= cfg_data[14:0];
        mdsw_pkg::CFG_SPEED_THR: speed_thr_r <= cfg_data[14:0];
        mdsw_pkg::CFG_FAIL_TIME: fail_time_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pins_r  <= 4'h0;
      rduty_r <= 10'd0;
      lduty_r <= 10'd0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (out_adv) begin
        out_v_r <= in_v_r;
      end
      if (fire) begin
        pins_r  <= pins_nxt;
        rduty_r <= rduty_nxt;
        lduty_r <= lduty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
    if (fire) begin
      out_data_r <= {7'd0, stall_o, clamped_o, lduty_nxt, rduty_nxt, pins_nxt};
    end
  end

endmodule

`default_nettype wire

>>> design/mdsw_drive_calc.sv
`default_nettype none

module mdsw_drive_calc #(
  parameter int DUTY_FULL = 1000
) (
  input  wire logic signed [15:0] drive_value,
  output logic signed [15:0]      clamped,
  output logic [14:0]             mag,
  output logic [9:0]              duty,
  output logic                    fwd
);

  localparam logic [15:0] DUTY_FULL_W = 16'(DUTY_FULL);

  logic signed [15:0] neg_v;
  logic [30:0]        prod;
  logic [16:0]        quot;

  always_comb begin
    if (drive_value > mdsw_pkg::Q_ONE) begin
      clamped = mdsw_pkg::Q_ONE;
    end else if (drive_value < mdsw_pkg::Q_NEG_ONE) begin
      clamped = mdsw_pkg::Q_NEG_ONE;
    end else begin
      clamped = drive_value;
    end
    neg_v = -clamped;
    mag   = clamped[15] ? neg_v[14:0] : clamped[14:0];
    fwd   = !clamped[15] && (clamped != 16'sd0);
    prod  = 31'(mag) * 31'(DUTY_FULL_W);
    quot  = prod[30:mdsw_pkg::Q_FRAC];
    duty  = (quot > mdsw_pkg::DUTY_MAX) ? mdsw_pkg::DUTY_MAX[9:0] : quot[9:0];
  end

endmodule

`default_nettype wire

>>> design/mdsw_wheel_watchdog.sv
`default_nettype none

module mdsw_wheel_watchdog (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mdsw_pkg::wd_ctl_t ctl,
  input  wire logic [31:0]     fail_time,
  output logic                 stall
);

  logic [31:0] good_r, good_nxt;
  logic [31:0] drv_r;
  logic [31:0] gap;
  logic [31:0] since_good;
  logic        keep;

  always_comb begin
    gap        = ctl.now - drv_r;
    since_good = ctl.now - good_r;
    // good time survives only if still blocked and the drive gap was short
    keep       = ctl.blocked && !(gap > {1'b0, fail_time[31:1]});
    stall      = keep && (since_good > fail_time);
    good_nxt   = keep ? good_r : ctl.now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r <= mdsw_pkg::TIME_RESET;
      drv_r  <= mdsw_pkg::TIME_RESET;
    end else if (ctl.upd) begin
      good_r <= good_nxt;
      drv_r  <= ctl.now;
    end
  end

endmodule

`default_nettype wire

>>> design/mdsw_checker.sv
`default_nettype none
`include "motor_drive_with_stall_watchdog_core_defines.svh"

module mdsw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  `MDSW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `MDSW_ASSERT_NOW(a_clamp_range, out_tvalid, !($signed(out_tdata[39:24]) > 16'sd16384 || $signed(out_tdata[39:24]) < -16'sd16384))
  `MDSW_ASSERT_NOW(a_stall_driven, out_tvalid && out_tdata[40], out_tdata[39:24] != 16'd0)
  `MDSW_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[47:41] == 7'd0)

endmodule

bind motor_drive_with_stall_watchdog_core mdsw_checker u_mdsw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

>>> tb/sv/motor_drive_checker.sv
`timescale 1ns / 100ps

module motor_drive_checker #(
  parameter int DUTY_FULL = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // drive_value[15:0], measured_speed[31:16], now_ms[63:32]
  input  logic [2:0]  in_tuser,   // command[1:0], wheel[2]
  input  logic        out_tvalid,
  input  logic        out_tready,
  // direction_pins[3:0], right_duty[13:4], left_duty[23:14], clamped_drive[39:24],
  // stall_fail[40], zero[47:41]
  input  logic [47:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          error_count,
  output int          pending_count
);
  import mdsw_pkg::*;

  typedef struct {
    logic [3:0]  pins;
    logic [9:0]  right_duty;
    logic [9:0]  left_duty;
    logic [15:0] clamped;
    logic        stall;
  } drive_result_t;

  logic [14:0] drive_thr;
  logic [14:0] speed_thr;
  logic [31:0] fail_ms;
  logic [31:0] good_ms [2];
  logic [31:0] drive_ms [2];
  logic [3:0]  pin_state;
  logic [9:0]  duty_state [2];

  drive_result_t expected_drive_results [$];

  initial begin
    error_count = 0;
    pending_count = 0;
  end

  function automatic logic [9:0] clip_duty(int unsigned d);
    if (d > DUTY_MAX)
      return DUTY_MAX[9:0];
    return d[9:0];
  endfunction

  function automatic void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    error_count++;
  endfunction

  // Applies one command to the drive state and queues the result it should produce.
  function automatic void predict_drive_result(logic [1:0] cmd, logic wheel,
                                               logic signed [15:0] dv,
                                               logic signed [15:0] spd, logic [31:0] now);
    int v;
    int s;
    int clamped;
    int mag;
    int smag;
    logic blocked;
    drive_result_t r;
    v = dv;
    s = spd;
    clamped = 0;
    r.stall = 1'b0;
    case (cmd)
      CMD_DRIVE: begin
        clamped = v > Q_ONE ? Q_ONE : (v < Q_NEG_ONE ? Q_NEG_ONE : v);
        mag = clamped < 0 ? -clamped : clamped;
        smag = s < 0 ? -s : s;
        duty_state[wheel] = clip_duty(mag * DUTY_FULL / (1 << Q_FRAC));
        if (wheel == 1'b0)
          pin_state[1:0] = clamped > 0 ? 2'b10 : 2'b01;
        else
          pin_state[3:2] = clamped > 0 ? 2'b01 : 2'b10;
        if (now - drive_ms[wheel] > (fail_ms >> 1))
          good_ms[wheel] = now;
        drive_ms[wheel] = now;
        blocked = mag > drive_thr && smag < speed_thr;
        if (!blocked)
          good_ms[wheel] = now;
        r.stall = (now - good_ms[wheel]) > fail_ms;
      end
      CMD_BRAKE, CMD_COAST: begin
        duty_state[0] = clip_duty(DUTY_FULL);
        duty_state[1] = clip_duty(DUTY_FULL);
        pin_state = cmd == CMD_BRAKE ? 4'hF : 4'h0;
      end
      default: ;
    endcase
    r.pins = pin_state;
    r.right_duty = duty_state[0];
    r.left_duty = duty_state[1];
    r.clamped = clamped[15:0];
    expected_drive_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    drive_result_t got;
    drive_result_t want;
    if (!rst_n) begin
      drive_thr = DRIVE_THR_RST;
      speed_thr = SPEED_THR_RST;
      fail_ms = FAIL_TIME_RST;
      good_ms[0] = TIME_RESET;
      good_ms[1] = TIME_RESET;
      drive_ms[0] = TIME_RESET;
      drive_ms[1] = TIME_RESET;
      pin_state = 4'h0;
      duty_state[0] = 10'd0;
      duty_state[1] = 10'd0;
      expected_drive_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.pins = out_tdata[3:0];
        got.right_duty = out_tdata[13:4];
        got.left_duty = out_tdata[23:14];
        got.clamped = out_tdata[39:24];
        got.stall = out_tdata[40];
        if (expected_drive_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual %h", $time, out_tdata);
          error_count++;
        end else begin
          want = expected_drive_results.pop_front();
          if (got.pins !== want.pins)
            report_mismatch("direction_pins", want.pins, got.pins);
          if (got.right_duty !== want.right_duty)
            report_mismatch("right_duty", want.right_duty, got.right_duty);
          if (got.left_duty !== want.left_duty)
            report_mismatch("left_duty", want.left_duty, got.left_duty);
          if (got.clamped !== want.clamped)
            report_mismatch("clamped_drive", want.clamped, got.clamped);
          if (got.stall !== want.stall)
            report_mismatch("stall_fail", want.stall, got.stall);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DRIVE_THR: drive_thr = cfg_data[14:0];
          CFG_SPEED_THR: speed_thr = cfg_data[14:0];
          CFG_FAIL_TIME: fail_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_drive_result(in_tuser[1:0], in_tuser[2], in_tdata[15:0], in_tdata[31:16],
                             in_tdata[63:32]);
    end
    pending_count = expected_drive_results.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import mdsw_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int HOLD_OFF_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int error_count;
  int pending_count;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int          idle_cycles = 0;

  logic [31:0] now_ms = 32'd0;
  int          drive_thr_cur = 8192;
  int          speed_thr_cur = 100;
  logic [31:0] fail_cur = 32'd1000;

  motor_drive_with_stall_watchdog_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  motor_drive_checker monitor_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Result side; a requested hold-off keeps tready low while the sender keeps pushing.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic wheel, int dv, int spd, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {now, spd[15:0], dv[15:0]};
    in_tuser <= {wheel, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DRIVE_THR: drive_thr_cur = val[14:0];
      CFG_SPEED_THR: speed_thr_cur = val[14:0];
      CFG_FAIL_TIME: fail_cur = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] dthr, logic [31:0] sthr, logic [31:0] fail);
    drain();
    write_reg(CFG_DRIVE_THR, dthr);
    write_reg(CFG_SPEED_THR, sthr);
    write_reg(CFG_FAIL_TIME, fail);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item;
    logic [1:0]  cmd;
    logic        wheel;
    int          dv;
    int          spd;
    int unsigned pick;
    int unsigned span;
    int unsigned step;
    pick = $urandom_range(99);
    cmd = pick < 80 ? CMD_DRIVE : pick < 88 ? CMD_BRAKE : pick < 95 ? CMD_COAST : CMD_UNUSED;
    wheel = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 40)
      dv = $urandom_range(32767, 10000);
    else if (pick < 70)
      dv = int'($urandom_range(65535)) - 32768;
    else if (pick < 90)
      dv = drive_thr_cur + int'($urandom_range(6)) - 3;
    else begin
      case ($urandom_range(4))
        0: dv = 0;
        1: dv = 16384;
        2: dv = 32767;
        3: dv = 1;
        default: dv = 32768;
      endcase
    end
    if ((pick < 40 || pick >= 70) && $urandom_range(1))
      dv = -dv;
    if (dv > 32767) dv = 32767;
    if (dv < -32768) dv = -32768;
    if ($urandom_range(1)) begin
      spd = $urandom_range(speed_thr_cur + 2);
      if ($urandom_range(1))
        spd = -spd;
    end else begin
      spd = int'($urandom_range(65535)) - 32768;
    end
    if (spd > 32767) spd = 32767;
    if (spd < -32768) spd = -32768;
    // mostly short steps so blocked runs build up to a stall
    span = fail_cur > 3000 ? 2252 : fail_cur * 3 / 4 + 2;
    pick = $urandom_range(99);
    if (pick < 10)
      step = 0;
    else if (pick < 80)
      step = $urandom_range(span);
    else if (pick < 95)
      step = $urandom_range(5000);
    else
      step = $urandom;
    now_ms += step;
    send_item(cmd, wheel, dv, spd, now_ms);
  endtask

  initial begin
    int p;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: drive 8192, speed 100, fail 1000
    send_item(CMD_DRIVE, 1'b0, 16384, 0, 32'd0);
    send_item(CMD_DRIVE, 1'b0, 32767, 5, 32'd600);
    send_item(CMD_DRIVE, 1'b0, -32768, -99, 32'd900);
    send_item(CMD_DRIVE, 1'b0, -16385, 0, 32'd1300);
    send_item(CMD_DRIVE, 1'b0, 16385, 0, 32'd1700);
    send_item(CMD_DRIVE, 1'b0, 20000, 0, 32'd2100);
    send_item(CMD_DRIVE, 1'b0, 8193, 100, 32'd2200);
    send_item(CMD_DRIVE, 1'b0, 8192, 0, 32'd2300);
    send_item(CMD_DRIVE, 1'b0, 0, -32768, 32'd2300);
    send_item(CMD_DRIVE, 1'b0, 1, 32767, 32'd2400);
    send_item(CMD_DRIVE, 1'b0, -1, 0, 32'd2400);
    send_item(CMD_DRIVE, 1'b1, 16384, 0, 32'd2500);
    send_item(CMD_DRIVE, 1'b1, -16384, 1, 32'd3000);
    send_item(CMD_DRIVE, 1'b1, 12000, -1, 32'd3500);
    send_item(CMD_DRIVE, 1'b1, 12000, 0, 32'd3501);
    send_item(CMD_BRAKE, 1'b1, 32767, -32768, 32'hFFFF_FFFF);
    send_item(CMD_COAST, 1'b0, -32768, 32767, 32'h8000_0000);
    send_item(CMD_UNUSED, 1'b1, -1, -1, 32'hFFFF_FFFF);
    send_item(CMD_DRIVE, 1'b1, 100, 0, 32'hFFFF_FFFF);
    send_item(CMD_DRIVE, 1'b1, -16384, 0, 32'hFFFF_FFFF);
    send_item(CMD_DRIVE, 1'b1, 16384, 0, 32'd600);
    send_item(CMD_DRIVE, 1'b0, -16384, 0, 32'd700);
    now_ms = 32'hFFFF_F000;

    for (p = 0; p < 8; p++) begin
      case (p)
        1: set_config(32'd0, 32'd32767, 32'd0);
        2: set_config(32'd16384, 32'd0, 32'hFFFF_FFFF);
        3: set_config($urandom_range(16384), $urandom_range(32767), $urandom_range(3000, 50));
        4: set_config($urandom, $urandom, $urandom);
        5: set_config(32'd8192, 32'd200, 32'd400);
        6: set_config(32'd12000, 32'd32767, 32'd1);
        7: set_config(DRIVE_THR_RST, SPEED_THR_RST, FAIL_TIME_RST);
        default: ;
      endcase
      case (p % 4)
        1: begin
          send_idle_pct = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 77;
        end
        3: begin
          send_idle_pct = 20;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (p == 4)
        hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    recv_stall_pct = 0;
    drain();
    repeat (10) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> motor_drive_with_stall_watchdog_core.f
+incdir+design
design/mdsw_pkg.sv
design/mdsw_drive_calc.sv
design/mdsw_wheel_watchdog.sv
design/motor_drive_with_stall_watchdog_core.sv
design/mdsw_checker.sv
tb/sv/motor_drive_checker.sv
tb/sv/tb.sv
